/* design/mti_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mti_pkg
// Shared constants, types and the fixed-point blend for the map table
// interpolator.
// ----------------------------------------------------------------------------
package mti_pkg;

    localparam int unsigned MAP_DEPTH = 1024;
    localparam int ADDR_W = $clog2(MAP_DEPTH);

    localparam int NUM_RD = 4;
    localparam int LANE_A0 = 0;
    localparam int LANE_A1 = 1;
    localparam int LANE_B0 = 2;
    localparam int LANE_B1 = 3;

    // raw address sums stay below 2^17 before the wrap
    localparam int RAW_W = 17;
    localparam int MOD_SH = RAW_W + ADDR_W;
    localparam int MUL_W = RAW_W + 2;
    localparam int PROD_W = RAW_W + MUL_W;
    localparam logic [63:0] MOD_MUL_W64 =
        ((64'd1 << MOD_SH) + 64'(MAP_DEPTH) - 64'd1) / 64'(MAP_DEPTH);
    localparam logic [MUL_W-1:0] MOD_MUL = MUL_W'(MOD_MUL_W64);
    localparam int DEP_W = ADDR_W + 1;
    localparam logic [DEP_W-1:0] DEPTH_C = DEP_W'(MAP_DEPTH);

    localparam logic [2:0] CMD_WRITE = 3'd0;
    localparam logic [2:0] CMD_INTERP1D = 3'd1;
    localparam logic [2:0] CMD_INTERP2D = 3'd2;
    localparam logic [2:0] CMD_NINE_PT = 3'd3;
    localparam logic [2:0] CMD_ELEVEN_PT = 3'd4;
    localparam logic [2:0] CMD_SEVENTEEN_PT = 3'd5;

    localparam logic [7:0] ELEVEN_KNEE = 8'h40;
    localparam logic [15:0] ELEVEN_OFFSET = 16'h0200;
    localparam logic [24:0] ROUND_HALF = 25'h80;

    typedef struct packed {
        logic        is_wr;
        logic        has_res;
        logic        two_d;
        logic [7:0]  fx;
        logic [7:0]  fy;
        logic [15:0] wdata;
    } ctrl_t;

    function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                          input logic [7:0] f);
        logic [8:0]  g;
        logic [24:0] s;
        g = 9'd256 - {1'b0, f};
        s = 25'(a) * 25'(g) + 25'(b) * 25'(f) + ROUND_HALF;
        return s[23:8];
    endfunction

endpackage

/* design/mti_addr_mod.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mti_addr_mod
// Three-stage wrap of a raw address sum modulo the table depth, by a
// multiply with the exact reciprocal, a multiply back and a subtract.
// ----------------------------------------------------------------------------
module mti_addr_mod (
    input  logic                          aclk,
    input  logic                          en_mul,
    input  logic                          en_qd,
    input  logic                          en_sub,
    input  logic [mti_pkg::RAW_W-1:0]     raw,
    output logic [mti_pkg::ADDR_W-1:0]    addr
);

    logic [mti_pkg::RAW_W-1:0]  x3_reg, x4_reg;
    logic [mti_pkg::PROD_W-1:0] xm_reg, xm_next;
    logic [mti_pkg::RAW_W-1:0]  q;
    logic [mti_pkg::RAW_W-1:0]  qd_reg, qd_next;
    logic [mti_pkg::ADDR_W-1:0] addr_reg, addr_next;

    assign xm_next = mti_pkg::PROD_W'(raw) * mti_pkg::PROD_W'(mti_pkg::MOD_MUL);
    assign q = mti_pkg::RAW_W'(xm_reg >> mti_pkg::MOD_SH);
    assign qd_next = mti_pkg::RAW_W'(mti_pkg::PROD_W'(q) * mti_pkg::PROD_W'(mti_pkg::DEPTH_C));
    assign addr_next = mti_pkg::ADDR_W'(x4_reg - qd_reg);

    always_ff @(posedge aclk) begin
        if (en_mul) begin
            x3_reg <= raw;
            xm_reg <= xm_next;
        end
        if (en_qd) begin
            x4_reg <= x3_reg;
            qd_reg <= qd_next;
        end
        if (en_sub) begin
            addr_reg <= addr_next;
        end
    end

    assign addr = addr_reg;

endmodule

/* design/mti_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mti_table
// Calibration table held in four identical copies: one shared write port,
// one registered read port per copy.
// ----------------------------------------------------------------------------
module mti_table (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [mti_pkg::ADDR_W-1:0] wr_addr,
    input  logic [15:0]                wr_data,
    input  logic                       rd_en,
    input  logic [mti_pkg::ADDR_W-1:0] rd_addr [mti_pkg::NUM_RD],
    output logic [15:0]                rd_data [mti_pkg::NUM_RD]
);

    for (genvar i = 0; i < mti_pkg::NUM_RD; i++) begin : g_copy
        logic [15:0] mem [mti_pkg::MAP_DEPTH];
        logic [15:0] rd_reg;

        always_ff @(posedge aclk) begin
            if (wr_en) begin
                mem[wr_addr] <= wr_data;
            end
            if (rd_en) begin
                rd_reg <= mem[rd_addr[i]];
            end
        end

        assign rd_data[i] = rd_reg;
    end

endmodule

/* design/mti_interp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mti_interp
// Row interpolation on the column fraction, then the row blend on the row
// fraction into the output register.
// ----------------------------------------------------------------------------
module mti_interp (
    input  logic                 aclk,
    input  logic                 en_row,
    input  logic                 en_out,
    input  logic [15:0]          rd_data [mti_pkg::NUM_RD],
    input  mti_pkg::ctrl_t       ctrl,
    output logic [15:0]          result
);

    logic [15:0] r0_reg, r0_next;
    logic [15:0] r1_reg, r1_next;
    logic [7:0]  fx_reg;
    logic        two_d_reg;
    logic [15:0] res_reg, res_next;

    assign r0_next = mti_pkg::blend(rd_data[mti_pkg::LANE_A0], rd_data[mti_pkg::LANE_A1],
                                    ctrl.fy);
    assign r1_next = mti_pkg::blend(rd_data[mti_pkg::LANE_B0], rd_data[mti_pkg::LANE_B1],
                                    ctrl.fy);
    assign res_next = two_d_reg ? mti_pkg::blend(r0_reg, r1_reg, fx_reg) : r0_reg;

    always_ff @(posedge aclk) begin
        if (en_row) begin
            r0_reg    <= r0_next;
            r1_reg    <= r1_next;
            fx_reg    <= ctrl.fx;
            two_d_reg <= ctrl.two_d;
        end
        if (en_out) begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

endmodule

/* design/map_table_interpolator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// map_table_interpolator
// Calibration table with 1D, 2D bilinear and remapped-site interpolation.
//
//   channel | ports                     | content
//   --------+---------------------------+------------------------------------
//   input   | s_tvalid s_tready s_tdata | cmd, map_base, write_data, site_x,
//           |                           | site_y, row_length
//   result  | m_tvalid m_tready m_tdata | result
//
// Eight register stages: operand capture, address sums, three-stage address
// wrap, table read, row blend, output blend. One item per cycle while the
// result channel does not stall. Write items update the table at the read
// stage and give no result.
// Reset clears the stage valid bits only; the table is not cleared.
// Each stage holds while the next one is full and stalled, so bubbles close
// up and input is taken while a result waits.
// ----------------------------------------------------------------------------
module map_table_interpolator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] cmd, [12:3] map_base, [28:13] write_data, [44:29] site_x,
    // [60:45] site_y, [68:61] row_length, [71:69] zero
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] result
    output logic [15:0] m_tdata
);

    logic [2:0]  in_cmd;
    logic [9:0]  in_base;
    logic [15:0] in_wdata;
    logic [15:0] in_sx;
    logic [15:0] in_sy;
    logic [7:0]  in_rl;
    logic [7:0]  in_v;
    logic [15:0] in_site;
    logic        in_legal;

    logic [8:1]  v_reg;
    logic [8:1]  en;

    logic [2:0]  s1_cmd_reg;
    logic [9:0]  s1_base_reg;
    logic [15:0] s1_wdata_reg;
    logic [7:0]  s1_fx_reg;
    logic [7:0]  s1_fy_reg;
    logic [7:0]  s1_yi_reg;
    logic [7:0]  s1_rl_reg;
    logic [15:0] s1_prod_reg, s1_prod_next;

    logic [mti_pkg::RAW_W-1:0]  row0;
    logic [mti_pkg::RAW_W-1:0]  raw_a;
    logic [mti_pkg::RAW_W-1:0]  raw_b;
    logic [mti_pkg::RAW_W-1:0]  raw_next [mti_pkg::NUM_RD];
    logic [mti_pkg::RAW_W-1:0]  raw_reg [mti_pkg::NUM_RD];
    logic [mti_pkg::ADDR_W-1:0] addr [mti_pkg::NUM_RD];
    logic [15:0]                rd_data [mti_pkg::NUM_RD];

    mti_pkg::ctrl_t c1;
    mti_pkg::ctrl_t c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;

    logic        wr_en;

    assign in_cmd   = s_tdata[2:0];
    assign in_base  = s_tdata[12:3];
    assign in_wdata = s_tdata[28:13];
    assign in_sx    = s_tdata[44:29];
    assign in_sy    = s_tdata[60:45];
    assign in_rl    = s_tdata[68:61];
    assign in_v     = in_sy[7:0];

    always_comb begin
        in_legal = 1'b1;
        in_site  = in_sy;
        case (in_cmd)
            mti_pkg::CMD_WRITE: begin
                in_site = 16'd0;
            end
            mti_pkg::CMD_INTERP1D, mti_pkg::CMD_INTERP2D: begin
                in_site = in_sy;
            end
            mti_pkg::CMD_NINE_PT: begin
                in_site = {5'd0, in_v, 3'd0};
            end
            mti_pkg::CMD_ELEVEN_PT: begin
                if (in_v > mti_pkg::ELEVEN_KNEE) begin
                    in_site = {5'd0, in_v, 3'd0} + mti_pkg::ELEVEN_OFFSET;
                end else begin
                    in_site = {4'd0, in_v, 4'd0};
                end
            end
            mti_pkg::CMD_SEVENTEEN_PT: begin
                in_site = {4'd0, in_v, 4'd0};
            end
            default: begin
                in_legal = 1'b0;
            end
        endcase
    end

    assign s1_prod_next = (in_cmd == mti_pkg::CMD_INTERP2D) ?
                          16'(in_sx[15:8]) * 16'(in_rl) : 16'd0;

    always_comb begin
        en[8] = !v_reg[8] || m_tready;
        for (int k = 7; k >= 1; k--) begin
            en[k] = !v_reg[k] || en[k + 1];
        end
    end

    assign s_tready = en[1];

    assign wr_en = v_reg[5] && c5_reg.is_wr && en[6];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[1]) v_reg[1] <= s_tvalid && in_legal;
            if (en[2]) v_reg[2] <= v_reg[1];
            if (en[3]) v_reg[3] <= v_reg[2];
            if (en[4]) v_reg[4] <= v_reg[3];
            if (en[5]) v_reg[5] <= v_reg[4];
            // drop write items once the table is updated
            if (en[6]) v_reg[6] <= v_reg[5] && c5_reg.has_res;
            if (en[7]) v_reg[7] <= v_reg[6];
            if (en[8]) v_reg[8] <= v_reg[7];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            s1_cmd_reg   <= in_cmd;
            s1_base_reg  <= in_base;
            s1_wdata_reg <= in_wdata;
            s1_fx_reg    <= in_sx[7:0];
            s1_fy_reg    <= in_site[7:0];
            s1_yi_reg    <= in_site[15:8];
            s1_rl_reg    <= in_rl;
            s1_prod_reg  <= s1_prod_next;
        end
    end

    assign row0  = mti_pkg::RAW_W'(s1_base_reg) + mti_pkg::RAW_W'(s1_prod_reg);
    assign raw_a = row0 + mti_pkg::RAW_W'(s1_yi_reg);
    assign raw_b = raw_a + mti_pkg::RAW_W'(s1_rl_reg);

    assign raw_next[mti_pkg::LANE_A0] = raw_a;
    assign raw_next[mti_pkg::LANE_A1] = raw_a + mti_pkg::RAW_W'(1);
    assign raw_next[mti_pkg::LANE_B0] = raw_b;
    assign raw_next[mti_pkg::LANE_B1] = raw_b + mti_pkg::RAW_W'(1);

    always_comb begin
        c1.is_wr   = (s1_cmd_reg == mti_pkg::CMD_WRITE);
        c1.has_res = (s1_cmd_reg != mti_pkg::CMD_WRITE);
        c1.two_d   = (s1_cmd_reg == mti_pkg::CMD_INTERP2D);
        c1.fx      = s1_fx_reg;
        c1.fy      = s1_fy_reg;
        c1.wdata   = s1_wdata_reg;
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            raw_reg <= raw_next;
            c2_reg  <= c1;
        end
        if (en[3]) c3_reg <= c2_reg;
        if (en[4]) c4_reg <= c3_reg;
        if (en[5]) c5_reg <= c4_reg;
        if (en[6]) c6_reg <= c5_reg;
    end

    for (genvar i = 0; i < mti_pkg::NUM_RD; i++) begin : g_wrap
        mti_addr_mod u_addr_mod (
            .aclk   (aclk),
            .en_mul (en[3]),
            .en_qd  (en[4]),
            .en_sub (en[5]),
            .raw    (raw_reg[i]),
            .addr   (addr[i])
        );
    end

    mti_table u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (addr[mti_pkg::LANE_A0]),
        .wr_data (c5_reg.wdata),
        .rd_en   (en[6]),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    mti_interp u_interp (
        .aclk    (aclk),
        .en_row  (en[7]),
        .en_out  (en[8]),
        .rd_data (rd_data),
        .ctrl    (c6_reg),
        .result  (m_tdata)
    );

    assign m_tvalid = v_reg[8];

endmodule

/* test/tb_mti_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mti_pkg
// Testbench types for the map table interpolator: the packed input item and
// the command codes the block does not use.
// ----------------------------------------------------------------------------
package tb_mti_pkg;

    // Matches s_tdata: cmd in the lowest bits, zero padding on top.
    typedef struct packed {
        logic [2:0]  pad;
        logic [7:0]  row_length;
        logic [15:0] site_y;
        logic [15:0] site_x;
        logic [15:0] write_data;
        logic [9:0]  map_base;
        logic [2:0]  cmd;
    } mti_item_t;

    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

endpackage

/* test/mti_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mti_checker
// Watches both channels of the map table interpolator, keeps its own copy of
// the calibration table, predicts the interpolated value of every accepted
// read item and compares each result, in order, with the oldest prediction.
// ----------------------------------------------------------------------------
module mti_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    output int          fail_count,
    output int          pending
);
    import mti_pkg::*;
    import tb_mti_pkg::*;

    logic [15:0] cal_points [MAP_DEPTH];
    logic [15:0] interp_values [$];
    logic [15:0] want;
    int          errors = 0;

    function automatic logic [15:0] weigh(input logic [15:0] a, input logic [15:0] b,
                                          input logic [7:0] f);
        int unsigned acc;
        acc = 32'(a) * (32'd256 - 32'(f)) + 32'(b) * 32'(f) + 32'h80;
        return acc[23:8];
    endfunction

    function automatic logic [15:0] point_at(input int unsigned addr);
        return cal_points[addr % MAP_DEPTH];
    endfunction

    function automatic logic [15:0] along_line(input int unsigned start,
                                               input logic [15:0] site);
        int unsigned idx;
        idx = start + 32'(site[15:8]);
        return weigh(point_at(idx), point_at(idx + 1), site[7:0]);
    endfunction

    function automatic logic [15:0] remap_site(input logic [2:0] cmd, input logic [7:0] v);
        case (cmd)
            CMD_NINE_PT: begin
                return {5'b0, v, 3'b0};
            end
            CMD_ELEVEN_PT: begin
                if (v > ELEVEN_KNEE) begin
                    return {5'b0, v, 3'b0} + ELEVEN_OFFSET;
                end
                return {4'b0, v, 4'b0};
            end
            default: begin
                return {4'b0, v, 4'b0};
            end
        endcase
    endfunction

    function automatic void predict_item(input mti_item_t it);
        int unsigned row0;
        logic [15:0] r0;
        logic [15:0] r1;
        case (it.cmd)
            CMD_WRITE: begin
                cal_points[32'(it.map_base) % MAP_DEPTH] = it.write_data;
            end
            CMD_INTERP1D: begin
                interp_values.push_back(along_line(32'(it.map_base), it.site_y));
            end
            CMD_INTERP2D: begin
                row0 = 32'(it.map_base) + 32'(it.site_x[15:8]) * 32'(it.row_length);
                r0 = along_line(row0, it.site_y);
                r1 = along_line(row0 + 32'(it.row_length), it.site_y);
                interp_values.push_back(weigh(r0, r1, it.site_x[7:0]));
            end
            CMD_NINE_PT, CMD_ELEVEN_PT, CMD_SEVENTEEN_PT: begin
                interp_values.push_back(along_line(32'(it.map_base),
                                                   remap_site(it.cmd, it.site_y[7:0])));
            end
            default: begin
            end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        errors++;
    endtask

    initial begin
        foreach (cal_points[i]) begin
            cal_points[i] = '0;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            interp_values.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (interp_values.size() == 0) begin
                    report_mismatch($sformatf("result %h with no item waiting", m_tdata));
                end else begin
                    want = interp_values.pop_front();
                    if (m_tdata !== want) begin
                        report_mismatch($sformatf("result %h, expected %h", m_tdata, want));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predict_item(mti_item_t'(s_tdata));
            end
        end
        fail_count <= errors;
        pending <= interp_values.size();
    end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Fills the whole calibration table, runs directed reads over the corners of
// every mode, then random traffic with random gaps, one long receiver
// hold-off and a stretch at full rate; the checker scores every result.
// ----------------------------------------------------------------------------
module tb_top;
    import mti_pkg::*;
    import tb_mti_pkg::*;

    localparam int RANDOM_ITEMS = 660;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    int fail_count;
    int pending;
    int idle_edges = 0;
    int hold_count;
    int unsigned n;
    bit quiet;
    bit hold_req;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    map_table_interpolator DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mti_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    function automatic bit take_break();
        return !quiet && ($urandom_range(99) < 35);
    endfunction

    function automatic mti_item_t make_item(input logic [2:0] cmd, input logic [9:0] base,
                                            input logic [15:0] wd, input logic [15:0] sx,
                                            input logic [15:0] sy, input logic [7:0] rl);
        mti_item_t it;
        it = '0;
        it.cmd = cmd;
        it.map_base = base;
        it.write_data = wd;
        it.site_x = sx;
        it.site_y = sy;
        it.row_length = rl;
        return it;
    endfunction

    function automatic mti_item_t random_item();
        int unsigned pick;
        logic [2:0]  cmd;
        pick = $urandom_range(99);
        if (pick < 25) begin
            cmd = CMD_WRITE;
        end else if (pick < 40) begin
            cmd = CMD_INTERP1D;
        end else if (pick < 60) begin
            cmd = CMD_INTERP2D;
        end else if (pick < 70) begin
            cmd = CMD_NINE_PT;
        end else if (pick < 80) begin
            cmd = CMD_ELEVEN_PT;
        end else if (pick < 92) begin
            cmd = CMD_SEVENTEEN_PT;
        end else if (pick < 96) begin
            cmd = CMD_SPARE_A;
        end else begin
            cmd = CMD_SPARE_B;
        end
        return make_item(cmd, 10'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), 8'($urandom));
    endfunction

    task automatic send_item(input mti_item_t it);
        @(negedge aclk);
        while (take_break()) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= it;
        do begin
            @(posedge aclk);
        end while (!s_tready);
    endtask

    // result side: random back-pressure plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && aresetn) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) begin
                    @(negedge aclk);
                end
            end
            m_tready <= aresetn && !take_break();
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_edges <= 0;
        end else if (idle_edges >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_edges <= idle_edges + 1;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        quiet = 1'b0;
        hold_req = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // write every entry before any read
        for (n = 0; n < MAP_DEPTH; n++) begin
            send_item(make_item(CMD_WRITE, 10'(n),
                                (n == 0 || n == MAP_DEPTH - 1) ? 16'hFFFF :
                                (n == 1) ? 16'h0000 : 16'($urandom),
                                16'($urandom), 16'($urandom), 8'($urandom)));
        end

        send_item(make_item(CMD_INTERP1D, 10'h3FF, 16'h1234, 16'h0000, 16'h00FF, 8'h00));
        send_item(make_item(CMD_INTERP1D, 10'h000, 16'h0000, 16'hFFFF, 16'h0000, 8'hFF));
        send_item(make_item(CMD_INTERP1D, 10'h200, 16'hFFFF, 16'h0000, 16'hFFFF, 8'h00));
        send_item(make_item(CMD_INTERP2D, 10'd100, 16'h0000, 16'h0380, 16'h1240, 8'h00));
        send_item(make_item(CMD_INTERP2D, 10'h3FF, 16'h0000, 16'hFFFF, 16'hFFFF, 8'hFF));
        send_item(make_item(CMD_INTERP2D, 10'h000, 16'h0000, 16'h0000, 16'h0000, 8'h01));
        send_item(make_item(CMD_INTERP2D, 10'd300, 16'h0000, 16'h0A01, 16'h0302, 8'd37));
        send_item(make_item(CMD_NINE_PT, 10'd1000, 16'h0000, 16'h0000, 16'hAB00, 8'h00));
        send_item(make_item(CMD_NINE_PT, 10'd7, 16'h0000, 16'h0000, 16'h00FF, 8'h00));
        send_item(make_item(CMD_ELEVEN_PT, 10'd1020, 16'h0000, 16'h0000, 16'h0040, 8'h00));
        send_item(make_item(CMD_ELEVEN_PT, 10'd1020, 16'h0000, 16'h0000, 16'h5541, 8'h00));
        send_item(make_item(CMD_ELEVEN_PT, 10'd40, 16'h0000, 16'h0000, 16'h0000, 8'h00));
        send_item(make_item(CMD_ELEVEN_PT, 10'd40, 16'h0000, 16'h0000, 16'hFFFF, 8'h00));
        send_item(make_item(CMD_SEVENTEEN_PT, 10'h3FF, 16'h0000, 16'h0000, 16'hFFFF, 8'h00));
        send_item(make_item(CMD_SEVENTEEN_PT, 10'd9, 16'h0000, 16'h0000, 16'h0080, 8'h00));
        send_item(make_item(CMD_SPARE_A, 10'h3FF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
        send_item(make_item(CMD_SPARE_B, 10'd5, 16'hA5A5, 16'h0101, 16'h0202, 8'h03));
        // read back right behind a write
        send_item(make_item(CMD_WRITE, 10'd5, 16'hFFFF, 16'h0000, 16'h0000, 8'h00));
        send_item(make_item(CMD_INTERP1D, 10'd5, 16'h0000, 16'h0000, 16'h0000, 8'h00));
        send_item(make_item(CMD_WRITE, 10'd6, 16'h0000, 16'h0000, 16'h0000, 8'h00));
        send_item(make_item(CMD_INTERP1D, 10'd5, 16'h0000, 16'h0000, 16'h0080, 8'h00));
        send_item(make_item(CMD_WRITE, 10'h3FF, 16'h0000, 16'h0000, 16'h0000, 8'h00));
        send_item(make_item(CMD_INTERP1D, 10'h3FE, 16'h0000, 16'h0000, 16'h01FF, 8'h00));

        hold_req = 1'b1;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            quiet = (n >= 300 && n < 500);
            send_item(random_item());
        end
        quiet = 1'b0;

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
